[hw/rtl/ese_pkg.sv]
// ----------------------------------------------------------------------------
// ese_pkg
// Shared types and constants for the encoder speed estimator: sequencer
// states, result status codes, configuration register indexes, step counts.
// ----------------------------------------------------------------------------
package ese_pkg;

  // Result status codes
  localparam logic [1:0] ST_INVALID = 2'd0;
  localparam logic [1:0] ST_PRIMED  = 2'd1;
  localparam logic [1:0] ST_NO_NEW  = 2'd2;
  localparam logic [1:0] ST_READY   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_COUNTS = 2'd0;
  localparam logic [1:0] CFG_DIRINV = 2'd1;
  localparam logic [1:0] CFG_TAU    = 2'd2;

  // Configuration reset values
  localparam logic [16:0] COUNTS_RST = 17'd4096;
  localparam logic [31:0] TAU_RST    = 32'd15915;

  // 60e6 us/min times 256 (Q24.8 output scale)
  localparam logic [33:0] RPM_SCALE = 34'd15360000000;

  // Bit-serial step counts
  localparam int MUL_STEPS  = 17;  // turn count register bits
  localparam int ALPHA_BITS = 16;  // alpha quotient bits
  localparam int DIV_STEPS  = 32;  // raw speed quotient bits
  localparam int FMUL_STEPS = 16;  // alpha multiplier bits

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_SETUP,
    S_MUL,
    S_RND,
    S_DIV,
    S_RAW,
    S_FSET,
    S_FMUL,
    S_FRND,
    S_FUPD,
    S_OUT
  } ese_state_e;

endpackage

[hw/rtl/ese_in_if.sv]
// ----------------------------------------------------------------------------
// ese_in_if
// Input channel: one encoder sample beat with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ese_in_if #(
  parameter int POS_W = 16
);
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position;
  logic [31:0]      sample_seq;
  logic [15:0]      period_us;

  modport source (output valid, output position, output sample_seq, output period_us,
                  input ready);
  modport sink   (input valid, input position, input sample_seq, input period_us,
                  output ready);
endinterface

[hw/rtl/ese_out_if.sv]
// ----------------------------------------------------------------------------
// ese_out_if
// Output channel: one speed result beat with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ese_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] raw_speed;
  logic signed [31:0] filtered_speed;
  logic               speed_valid;

  modport source (output valid, output status, output raw_speed,
                  output filtered_speed, output speed_valid, input ready);
  modport sink   (input valid, input status, input raw_speed,
                  input filtered_speed, input speed_valid, output ready);
endinterface

[hw/rtl/encoder_speed_estimator.sv]
// ----------------------------------------------------------------------------
// encoder_speed_estimator
// Flow: a beat that is invalid, priming or carries no new sample goes from
//   evaluation straight to the output register; a speed update first runs
//   the bit-serial multipliers (17 steps), the raw speed divider (32 steps) and the
//   filter multiplier (16 steps), one after another on one beat at a time; no new
//   beat is taken until the result has been loaded into the output register.
// Reset: asynchronous, active low; control and estimator state and speeds clear, the config
//   registers return to their defaults, no result is pending.
// ----------------------------------------------------------------------------
module encoder_speed_estimator #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ese_in_if.sink      in_if,
  ese_out_if.source   out_if,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import ese_pkg::*;

  // position compare width: covers the field and the turn count
  localparam int CW = (POSITION_BITS > 17) ? POSITION_BITS : 17;

  // configuration
  logic [16:0] counts_q;
  logic        dir_inv_q;
  logic [31:0] tau_q;

  // estimator state
  logic [POSITION_BITS-1:0] prev_pos_q, prev_pos_d;
  logic [31:0]              prev_seq_q, prev_seq_d;
  logic [31:0]              elapsed_q, elapsed_d;
  logic signed [31:0]       raw_q, raw_d;
  logic signed [31:0]       filt_q, filt_d;
  logic                     primed_q, primed_d;
  logic                     vflag_q, vflag_d;

  // control
  ese_state_e  state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;

  // captured beat and result status
  logic [POSITION_BITS-1:0] pos_in_q, pos_in_d;
  logic [31:0]              seq_in_q, seq_in_d;
  logic [15:0]              period_in_q, period_in_d;
  logic [1:0]               status_q, status_d;

  // raw speed datapath
  logic [15:0] dmag_q, dmag_d;
  logic        dneg_q, dneg_d;
  logic [15:0] num_b_q, num_b_d;
  logic [49:0] num_mc_q, num_mc_d, num_acc_q, num_acc_d;
  logic [16:0] den_b_q, den_b_d;
  logic [48:0] den_mc_q, den_mc_d, den_acc_q, den_acc_d;
  logic [48:0] rem_q, rem_d;
  logic [31:0] dvd_q, dvd_d;
  logic [31:0] quo_q, quo_d;
  logic        ovf_q, ovf_d;

  // alpha divider
  logic [32:0] adiv_q, adiv_d;
  logic [32:0] arem_q, arem_d;
  logic [15:0] aquo_q, aquo_d;

  // filter datapath
  logic        fneg_q, fneg_d;
  logic [15:0] fmul_b_q, fmul_b_d;
  logic [48:0] fmc_q, fmc_d, facc_q, facc_d;
  logic [32:0] rmag_q, rmag_d;

  // output register
  logic [1:0]         res_status_q, res_status_d;
  logic signed [31:0] res_raw_q, res_raw_d;
  logic signed [31:0] res_filt_q, res_filt_d;
  logic               res_vld_q, res_vld_d;

  // combinational temporaries
  logic [CW-1:0]      pos_ext, prev_ext, cnt_ext;
  logic [32:0]        el_sum;
  logic signed [18:0] dlt, dwr, half, cnt19;
  logic [50:0]        np;
  logic [49:0]        dtry;
  logic [33:0]        atry;
  logic signed [32:0] fdiff;
  logic [48:0]        fround;
  logic signed [33:0] fnext;
  logic [15:0]        alpha;

  assign in_if.ready = (state_q == S_IDLE);

  assign out_if.valid          = out_valid_q;
  assign out_if.status         = res_status_q;
  assign out_if.raw_speed      = res_raw_q;
  assign out_if.filtered_speed = res_filt_q;
  assign out_if.speed_valid    = res_vld_q;

  // sequencer and datapath next values
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && !out_if.ready;
    prev_pos_d   = prev_pos_q;
    prev_seq_d   = prev_seq_q;
    elapsed_d    = elapsed_q;
    raw_d        = raw_q;
    filt_d       = filt_q;
    primed_d     = primed_q;
    vflag_d      = vflag_q;
    pos_in_d     = pos_in_q;
    seq_in_d     = seq_in_q;
    period_in_d  = period_in_q;
    status_d     = status_q;
    dmag_d       = dmag_q;
    dneg_d       = dneg_q;
    num_b_d      = num_b_q;
    num_mc_d     = num_mc_q;
    num_acc_d    = num_acc_q;
    den_b_d      = den_b_q;
    den_mc_d     = den_mc_q;
    den_acc_d    = den_acc_q;
    rem_d        = rem_q;
    dvd_d        = dvd_q;
    quo_d        = quo_q;
    ovf_d        = ovf_q;
    adiv_d       = adiv_q;
    arem_d       = arem_q;
    aquo_d       = aquo_q;
    fneg_d       = fneg_q;
    fmul_b_d     = fmul_b_q;
    fmc_d        = fmc_q;
    facc_d       = facc_q;
    rmag_d       = rmag_q;
    res_status_d = res_status_q;
    res_raw_d    = res_raw_q;
    res_filt_d   = res_filt_q;
    res_vld_d    = res_vld_q;

    pos_ext  = CW'(pos_in_q);
    prev_ext = CW'(prev_pos_q);
    cnt_ext  = CW'(counts_q);
    el_sum   = {1'b0, elapsed_q} + 33'(period_in_q);
    // wrap the delta into half a turn
    half     = $signed({3'b000, counts_q[16:1]});
    cnt19    = $signed({2'b00, counts_q});
    dlt      = $signed({2'b00, pos_ext[16:0]}) - $signed({2'b00, prev_ext[16:0]});
    if (dlt > half) begin
      dwr = dlt - cnt19;
    end else if (dlt < -half) begin
      dwr = dlt + cnt19;
    end else begin
      dwr = dlt;
    end
    np     = {1'b0, num_acc_q} + 51'(den_acc_q >> 1);
    dtry   = {rem_q, dvd_q[31]};
    atry   = {arem_q, 1'b0};
    fdiff  = $signed({raw_q[31], raw_q}) - $signed({filt_q[31], filt_q});
    fround = facc_q + 49'h8000;
    fnext  = fneg_q ? ($signed({filt_q[31], filt_q[31], filt_q}) - $signed({1'b0, rmag_q}))
                    : ($signed({filt_q[31], filt_q[31], filt_q}) + $signed({1'b0, rmag_q}));
    alpha  = (tau_q == 32'd0) ? 16'hFFFF : aquo_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_if.valid) begin
          pos_in_d    = in_if.position;
          seq_in_d    = in_if.sample_seq;
          period_in_d = in_if.period_us;
          state_d     = S_EVAL;
        end
      end

      // validity, priming, elapsed time and delta
      S_EVAL: begin
        if (counts_q < 17'd2 || pos_ext >= cnt_ext || period_in_q == 16'd0) begin
          status_d = ST_INVALID;
          state_d  = S_OUT;
        end else if (!primed_q) begin
          prev_pos_d = pos_in_q;
          prev_seq_d = seq_in_q;
          elapsed_d  = 32'd0;
          primed_d   = 1'b1;
          status_d   = ST_PRIMED;
          state_d    = S_OUT;
        end else begin
          elapsed_d = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];
          if (seq_in_q == prev_seq_q) begin
            status_d = ST_NO_NEW;
            state_d  = S_OUT;
          end else begin
            dmag_d   = dwr[18] ? 16'(-dwr) : dwr[15:0];
            dneg_d   = (dwr != 19'sd0) && (dwr[18] ^ dir_inv_q);
            status_d = ST_READY;
            state_d  = S_SETUP;
          end
        end
      end

      // load the serial multipliers and the alpha divider
      S_SETUP: begin
        num_b_d   = dmag_q;
        num_mc_d  = 50'(RPM_SCALE);
        num_acc_d = '0;
        den_b_d   = counts_q;
        den_mc_d  = 49'(elapsed_q);
        den_acc_d = '0;
        adiv_d    = {1'b0, tau_q} + 33'(elapsed_q);
        arem_d    = 33'(elapsed_q);
        aquo_d    = '0;
        cnt_d     = '0;
        state_d   = S_MUL;
      end

      // shift-add: numerator and denominator; alpha division alongside
      S_MUL: begin
        if (num_b_q[0]) num_acc_d = num_acc_q + num_mc_q;
        if (den_b_q[0]) den_acc_d = den_acc_q + den_mc_q;
        num_b_d  = num_b_q >> 1;
        den_b_d  = den_b_q >> 1;
        num_mc_d = num_mc_q << 1;
        den_mc_d = den_mc_q << 1;
        if (cnt_q < 5'(ALPHA_BITS)) begin
          if (atry >= {1'b0, adiv_q}) begin
            arem_d = 33'(atry - {1'b0, adiv_q});
            aquo_d = {aquo_q[14:0], 1'b1};
          end else begin
            arem_d = atry[32:0];
            aquo_d = {aquo_q[14:0], 1'b0};
          end
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(MUL_STEPS - 1)) state_d = S_RND;
      end

      // add half the divisor for rounding, check quotient range
      S_RND: begin
        ovf_d   = 49'(np[50:32]) >= den_acc_q;
        rem_d   = 49'(np[50:32]);
        dvd_d   = np[31:0];
        quo_d   = '0;
        cnt_d   = '0;
        state_d = S_DIV;
      end

      // restoring division, one quotient bit per cycle
      S_DIV: begin
        if (dtry >= {1'b0, den_acc_q}) begin
          rem_d = 49'(dtry - {1'b0, den_acc_q});
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = dtry[48:0];
          quo_d = {quo_q[30:0], 1'b0};
        end
        dvd_d = dvd_q << 1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(DIV_STEPS - 1)) state_d = S_RAW;
      end

      // apply sign and saturate the raw speed
      S_RAW: begin
        if (ovf_q || quo_q[31]) begin
          raw_d = dneg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
          raw_d = dneg_q ? -$signed(quo_q) : $signed(quo_q);
        end
        state_d = S_FSET;
      end

      // filter error magnitude times alpha
      S_FSET: begin
        fneg_d   = fdiff[32];
        fmc_d    = 49'(fdiff[32] ? 33'(-fdiff) : fdiff);
        facc_d   = '0;
        fmul_b_d = alpha;
        cnt_d    = '0;
        state_d  = S_FMUL;
      end

      S_FMUL: begin
        if (fmul_b_q[0]) facc_d = facc_q + fmc_q;
        fmc_d    = fmc_q << 1;
        fmul_b_d = fmul_b_q >> 1;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == 5'(FMUL_STEPS - 1)) state_d = S_FRND;
      end

      S_FRND: begin
        rmag_d  = fround[48:16];
        state_d = S_FUPD;
      end

      // filter update with saturation, commit the sample
      S_FUPD: begin
        if (fnext[33:31] == 3'b000 || fnext[33:31] == 3'b111) begin
          filt_d = fnext[31:0];
        end else begin
          filt_d = fnext[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        prev_pos_d = pos_in_q;
        prev_seq_d = seq_in_q;
        elapsed_d  = 32'd0;
        vflag_d    = 1'b1;
        state_d    = S_OUT;
      end

      // hand the result to the output register
      S_OUT: begin
        if (!out_valid_q || out_if.ready) begin
          res_status_d = status_q;
          res_raw_d    = raw_q;
          res_filt_d   = filt_q;
          res_vld_d    = vflag_q;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control, configuration and estimator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      counts_q    <= COUNTS_RST;
      dir_inv_q   <= 1'b0;
      tau_q       <= TAU_RST;
      prev_pos_q  <= '0;
      prev_seq_q  <= '0;
      elapsed_q   <= '0;
      raw_q       <= '0;
      filt_q      <= '0;
      primed_q    <= 1'b0;
      vflag_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      prev_pos_q  <= prev_pos_d;
      prev_seq_q  <= prev_seq_d;
      elapsed_q   <= elapsed_d;
      raw_q       <= raw_d;
      filt_q      <= filt_d;
      primed_q    <= primed_d;
      vflag_q     <= vflag_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_COUNTS: counts_q  <= cfg_data_i[16:0];
          CFG_DIRINV: dir_inv_q <= cfg_data_i[0];
          CFG_TAU:    tau_q     <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_in_q     <= pos_in_d;
    seq_in_q     <= seq_in_d;
    period_in_q  <= period_in_d;
    status_q     <= status_d;
    dmag_q       <= dmag_d;
    dneg_q       <= dneg_d;
    num_b_q      <= num_b_d;
    num_mc_q     <= num_mc_d;
    num_acc_q    <= num_acc_d;
    den_b_q      <= den_b_d;
    den_mc_q     <= den_mc_d;
    den_acc_q    <= den_acc_d;
    rem_q        <= rem_d;
    dvd_q        <= dvd_d;
    quo_q        <= quo_d;
    ovf_q        <= ovf_d;
    adiv_q       <= adiv_d;
    arem_q       <= arem_d;
    aquo_q       <= aquo_d;
    fneg_q       <= fneg_d;
    fmul_b_q     <= fmul_b_d;
    fmc_q        <= fmc_d;
    facc_q       <= facc_d;
    rmag_q       <= rmag_d;
    res_status_q <= res_status_d;
    res_raw_q    <= res_raw_d;
    res_filt_q   <= res_filt_d;
    res_vld_q    <= res_vld_d;
  end

  // speed valid is sticky
  a_vflag_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vflag_q |=> vflag_q)
    else $error("speed valid flag dropped");

  // a speed update needs a primed block
  a_vflag_primed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vflag_q |-> primed_q)
    else $error("speed valid without priming");

  // divider remainder stays below the divisor unless the quotient overflows
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && !ovf_q) |-> (rem_q < den_acc_q))
    else $error("raw speed divider remainder out of range");

  // alpha divider remainder stays below the divisor
  a_alpha_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL && tau_q != 32'd0) |-> (arem_q < adiv_q))
    else $error("alpha divider remainder out of range");

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb - encoder speed estimator testbench
// Drives encoder samples into the estimator and checks every speed result
// against a cycle-free predictor of the fixed-point speed math. A short list
// of directed samples comes first. A run of no-new-sample beats with long
// periods then builds up the elapsed time. Random samples follow under a
// series of register settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ese_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 80;
  localparam int SOAK_BEATS     = 20;  // stale beats at the longest period

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] raw_speed;
    logic signed [31:0] filt_speed;
    logic               speed_valid;
  } speed_beat_t;

  typedef struct {
    logic [15:0] position;
    logic [31:0] seq;
    logic [15:0] period;
    bit          typed;
    speed_beat_t want;
  } sample_row_t;

  typedef struct {
    logic [16:0] counts;
    bit          invert;
    logic [31:0] tau;
    int          beats;
    bit          gaps;
    bit          shuffle;
  } setting_t;

  localparam speed_beat_t BLANK_INVALID = '{ST_INVALID, 32'sd0, 32'sd0, 1'b0};
  localparam speed_beat_t BLANK_PRIMED  = '{ST_PRIMED, 32'sd0, 32'sd0, 1'b0};
  localparam speed_beat_t BLANK_NO_NEW  = '{ST_NO_NEW, 32'sd0, 32'sd0, 1'b0};

  // Directed samples, run under the reset settings
  sample_row_t dir_rows [14] = '{
    '{16'd0,     32'd5,          16'd0,     1'b1, BLANK_INVALID},  // zero period
    '{16'd4096,  32'd5,          16'd100,   1'b1, BLANK_INVALID},  // position off the turn
    '{16'd65535, 32'd5,          16'd65535, 1'b1, BLANK_INVALID},
    '{16'd100,   32'd7,          16'd1000,  1'b1, BLANK_PRIMED},   // first valid sample primes
    '{16'd4000,  32'd7,          16'd1000,  1'b1, BLANK_NO_NEW},   // same sequence
    '{16'd200,   32'd8,          16'd1000,  1'b0, '0},             // plain forward step
    '{16'd4000,  32'd9,          16'd1,     1'b0, '0},             // wraps backward
    '{16'd50,    32'd10,         16'd65535, 1'b0, '0},             // wraps forward over zero
    '{16'd2098,  32'd11,         16'd500,   1'b0, '0},             // exactly half a turn up
    '{16'd50,    32'd12,         16'd500,   1'b0, '0},             // exactly half a turn down
    '{16'd50,    32'hFFFF_FFFF,  16'd1,     1'b0, '0},             // no motion
    '{16'd2098,  32'd0,          16'd1,     1'b0, '0},             // positive rpm saturates
    '{16'd50,    32'd1,          16'd1,     1'b0, '0},             // negative rpm saturates
    '{16'd4096,  32'd2,          16'd1,     1'b0, '0}              // invalid keeps the speeds
  };

  // Register settings for the random part; the last one runs without gaps
  setting_t settings [10] = '{
    '{17'd4096,   1'b0, 32'd15915,      150, 1'b1, 1'b0},
    '{17'd65536,  1'b1, 32'd1,          150, 1'b1, 1'b0},
    '{17'd2,      1'b0, 32'd0,           80, 1'b1, 1'b0},  // zero time constant
    '{17'd131071, 1'b1, 32'hFFFF_FFFF,  120, 1'b1, 1'b0},  // counts past one turn of 16 bits
    '{17'd1,      1'b0, 32'd100,         20, 1'b1, 1'b0},  // counts too small
    '{17'd0,      1'b1, 32'd7,           20, 1'b1, 1'b0},
    '{17'd1000,   1'b1, 32'd50000,      150, 1'b0, 1'b0},
    '{17'd65535,  1'b0, 32'd200,        150, 1'b1, 1'b0},
    '{17'd4096,   1'b0, 32'd15915,      150, 1'b1, 1'b1},  // random settings
    '{17'd3,      1'b1, 32'd1000,       160, 1'b0, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;

  ese_in_if #(.POS_W(16)) in_ch ();
  ese_out_if              out_ch ();

  encoder_speed_estimator #(
    .POSITION_BITS(16)
  ) DUT (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow copy of the registers
  logic [16:0] cpt    = COUNTS_RST;
  bit          invert = 1'b0;
  logic [31:0] tau    = TAU_RST;

  // Shadow copy of the estimator state
  logic [15:0]        last_pos  = '0;
  logic [31:0]        last_seq  = '0;
  logic [31:0]        acc_us    = '0;
  logic signed [31:0] raw_q     = '0;
  logic signed [31:0] filt_q    = '0;
  bit                 is_primed = 1'b0;
  bit                 has_speed = 1'b0;

  speed_beat_t  pending_speeds [$];
  int           error_count = 0;
  int           quiet_cycles = 0;
  int unsigned  stall_left = 0;
  bit           gaps_on = 1'b0;

  function automatic logic signed [31:0] clamp_i32(bit neg, logic [63:0] mag);
    if (neg)
      return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - mag);
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  // Speed predictor: advances the shadow state by one sample
  function automatic speed_beat_t estimate_speed(logic [15:0] pos, logic [31:0] seq,
                                                 logic [15:0] per);
    speed_beat_t res;
    logic [32:0] acc_sum;
    longint      delta, half, span, diff, next, p_now, p_old;
    logic [63:0] num, den, mag, alpha;
    bit          neg;
    res.status = ST_INVALID;
    if (cpt >= 17'd2 && 17'(pos) < cpt && per != 16'd0) begin
      if (!is_primed) begin
        last_pos   = pos;
        last_seq   = seq;
        acc_us     = '0;
        is_primed  = 1'b1;
        res.status = ST_PRIMED;
      end else begin
        acc_sum = {1'b0, acc_us} + 33'(per);
        acc_us  = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
        if (seq == last_seq) begin
          res.status = ST_NO_NEW;
        end else begin
          // wrap the delta to within half a turn
          p_now = pos;
          p_old = last_pos;
          span  = cpt;
          half  = cpt >> 1;
          delta = p_now - p_old;
          if (delta > half) delta = delta - span;
          else if (delta < -half) delta = delta + span;
          if (invert) delta = -delta;
          // raw rpm, rounded half away from zero
          neg   = delta < 0;
          num   = neg ? -delta : delta;
          num   = num * RPM_SCALE;
          den   = 64'(cpt) * 64'(acc_us);
          mag   = (num + den / 2) / den;
          raw_q = clamp_i32(neg, mag);
          // low-pass step with alpha in Q0.16
          alpha = {acc_us, 16'd0} / (64'(tau) + 64'(acc_us));
          if (alpha > 64'hFFFF) alpha = 64'hFFFF;
          diff   = longint'(raw_q) - longint'(filt_q);
          neg    = diff < 0;
          mag    = neg ? -diff : diff;
          mag    = (mag * alpha + 64'h8000) >> 16;
          next   = longint'(filt_q) + (neg ? -longint'(mag) : longint'(mag));
          filt_q = clamp_i32(next < 0, (next < 0) ? -next : next);
          last_pos   = pos;
          last_seq   = seq;
          acc_us     = '0;
          has_speed  = 1'b1;
          res.status = ST_READY;
        end
      end
    end
    res.raw_speed   = raw_q;
    res.filt_speed  = filt_q;
    res.speed_valid = has_speed;
    return res;
  endfunction

  // Present one sample and hold it until the handshake completes
  task automatic send_sample(logic [15:0] pos, logic [31:0] seq, logic [15:0] per,
                             bit typed, speed_beat_t want);
    speed_beat_t guess;
    in_ch.valid      <= 1'b1;
    in_ch.position   <= pos;
    in_ch.sample_seq <= seq;
    in_ch.period_us  <= per;
    do @(posedge clk); while (!in_ch.ready);
    guess = estimate_speed(pos, seq, per);
    pending_speeds.push_back(typed ? want : guess);
  endtask

  // Sender gap with junk on the payload
  task automatic hold_off(int unsigned n);
    in_ch.valid      <= 1'b0;
    in_ch.position   <= 16'($urandom);
    in_ch.sample_seq <= $urandom;
    in_ch.period_us  <= 16'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // Stop sending until every expected result is back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_speeds.size() != 0);
  endtask

  task automatic load_settings(logic [16:0] counts, bit inv, logic [31:0] tc);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_COUNTS;
    cfg_data <= {15'd0, counts};
    @(posedge clk);
    cfg_idx  <= CFG_DIRINV;
    cfg_data <= {31'd0, inv};
    @(posedge clk);
    cfg_idx  <= CFG_TAU;
    cfg_data <= tc;
    @(posedge clk);
    cfg_we <= 1'b0;
    cpt    = counts;
    invert = inv;
    tau    = tc;
    @(posedge clk);
  endtask

  // Result receiver with random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left   <= 0;
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 9) == 0) begin
      stall_left   <= $urandom_range(0, 18);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin : check_results
    speed_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_speeds.size() == 0) begin
        $display("%0t: result beat expected none actual status %0d", $time, out_ch.status);
        error_count++;
      end else begin
        want = pending_speeds.pop_front();
        if (out_ch.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, want.status, out_ch.status);
          error_count++;
        end
        if (out_ch.raw_speed !== want.raw_speed) begin
          $display("%0t: raw_speed expected %0d actual %0d",
                   $time, want.raw_speed, out_ch.raw_speed);
          error_count++;
        end
        if (out_ch.filtered_speed !== want.filt_speed) begin
          $display("%0t: filtered_speed expected %0d actual %0d",
                   $time, want.filt_speed, out_ch.filtered_speed);
          error_count++;
        end
        if (out_ch.speed_valid !== want.speed_valid) begin
          $display("%0t: speed_valid expected %0d actual %0d",
                   $time, want.speed_valid, out_ch.speed_valid);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no beat for %0d cycles", $time, quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [15:0] pos;
    logic [31:0] seq;
    logic [15:0] per;
    logic [31:0] seq_cursor;
    int          r, top, pos_i;
    setting_t    cur;

    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= CFG_COUNTS;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.position   <= '0;
    in_ch.sample_seq <= '0;
    in_ch.period_us  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed samples under the reset settings
    gaps_on = 1'b1;
    foreach (dir_rows[i]) begin
      if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 19));
      send_sample(dir_rows[i].position, dir_rows[i].seq, dir_rows[i].period,
                  dir_rows[i].typed, dir_rows[i].want);
    end
    drain_results();

    // Elapsed time build-up: run of stale samples, then one update
    gaps_on = 1'b0;
    repeat (SOAK_BEATS)
      send_sample(16'($urandom_range(0, 4095)), last_seq, 16'hFFFF, 1'b0, '0);
    send_sample(16'd77, last_seq + 32'd1, 16'd1, 1'b0, '0);
    drain_results();
    seq_cursor = last_seq + 32'd1;

    // Random samples under each register setting
    foreach (settings[p]) begin
      cur = settings[p];
      if (cur.shuffle) begin
        cur.counts = 17'($urandom_range(2, 70000));
        cur.invert = 1'($urandom_range(0, 1));
        cur.tau    = $urandom;
      end
      drain_results();
      repeat (2) @(posedge clk);
      load_settings(cur.counts, cur.invert, cur.tau);
      gaps_on = cur.gaps;
      repeat (cur.beats) begin
        if (gaps_on && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 19));
        if (gaps_on && $urandom_range(0, 60) == 0) drain_results();
        r = $urandom_range(0, 99);
        if (cpt < 17'd2) begin
          pos = 16'($urandom);
          seq = $urandom;
          per = 16'($urandom);
        end else begin
          top = (cpt > 17'd65536) ? 65535 : int'(cpt) - 1;
          // mostly small moves around the last position
          if ($urandom_range(0, 2) != 0) begin
            pos_i = int'(last_pos) + int'($urandom_range(0, 64)) - 32;
            if (pos_i < 0 || pos_i > top) pos_i = $urandom_range(0, top);
          end else begin
            pos_i = $urandom_range(0, top);
          end
          pos = pos_i[15:0];
          case ($urandom_range(0, 9))
            0:       per = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'd1;
            1, 2, 3: per = 16'($urandom_range(1, 65535));
            default: per = 16'($urandom_range(1, 2000));
          endcase
          if (r < 20) begin
            seq = last_seq;
          end else begin
            seq_cursor = ($urandom_range(0, 4) == 0) ? $urandom : seq_cursor + 32'd1;
            seq        = seq_cursor;
          end
          // broken samples
          if (r >= 94) per = 16'd0;
          else if (r >= 88 && top < 65535) pos = 16'($urandom_range(top + 1, 65535));
        end
        send_sample(pos, seq, per, 1'b0, '0);
      end
    end

    gaps_on = 1'b0;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
hw/rtl/ese_pkg.sv
hw/rtl/ese_in_if.sv
hw/rtl/ese_out_if.sv
hw/rtl/encoder_speed_estimator.sv
tb/sv/tb.sv
